@@ sv/sqvs_pkg.sv @@
// Shared types, constants and the quarter-wave sine table for the sprite quad setup.
package sqvs_pkg;

   localparam int SINE_TABLE_LOG2 = 10;
   localparam int QSH = 16 - SINE_TABLE_LOG2;          // dropped angle bits
   localparam int QTR = 1 << (SINE_TABLE_LOG2 - 2);    // table steps per quarter
   localparam int IDX_W = SINE_TABLE_LOG2 - 1;         // index 0..QTR
   localparam logic [15:0] ANG_MASK = 16'(~((32'd1 << QSH) - 32'd1));

   localparam int SQ_DEPTH = 2;
   localparam int SQ_PTR_W = (SQ_DEPTH > 1) ? $clog2(SQ_DEPTH) : 1;
   localparam int OB_DEPTH = 2;
   localparam int OB_PTR_W = (OB_DEPTH > 1) ? $clog2(OB_DEPTH) : 1;

   localparam logic [1:0] CORNER_TL = 2'd0;
   localparam logic [1:0] CORNER_TR = 2'd1;
   localparam logic [1:0] CORNER_BR = 2'd2;
   localparam logic [1:0] CORNER_BL = 2'd3;

   localparam logic REG_OFFSET_X = 1'b0;
   localparam logic REG_OFFSET_Y = 1'b1;

   localparam logic [63:0] PI_Q30 = 64'd3373259426;
   localparam logic [63:0] Q30_ONE = 64'd1 << 30;

   typedef struct packed {
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic [15:0] pos_z;
      logic [31:0] sprite_scale;
      logic [31:0] anim_scale;
      logic [15:0] sprite_angle;
      logic [15:0] anim_angle;
      logic [31:0] sprite_color;
      logic [31:0] anim_color;
      logic [31:0] cell_size;
      logic [31:0] cell_uv;
      logic [31:0] cell_tex_size;
   } sprite_in_type;

   // per-sprite record handed from front to back
   typedef struct packed {
      logic signed [16:0] cx;
      logic signed [16:0] cy;
      logic [15:0] z;
      logic [31:0] color;
      logic [15:0] u0;
      logic [15:0] u1;
      logic [15:0] v0;
      logic [15:0] v1;
      logic signed [41:0] p_chx;   // cos * hx
      logic signed [41:0] p_shy;   // sin * hy
      logic signed [41:0] p_shx;   // sin * hx
      logic signed [41:0] p_chy;   // cos * hy
   } sprite_type;

   typedef struct packed {
      logic [1:0] corner;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic [15:0] z;
      logic [31:0] color;
      logic [15:0] u;
      logic [15:0] v;
      logic last;
   } vertex_type;

   typedef logic [14:0] sin_tab_type [0:QTR];

   function automatic logic [14:0] quarter_sin(input logic [63:0] r);
      logic [63:0] t, t2, acc, term;
      t = (r * PI_Q30) >> 15;
      t2 = (t * t) >> 30;
      acc = Q30_ONE;
      term = ((t2 * acc) >> 30) / 64'd110;
      acc = (term >= Q30_ONE) ? 64'd0 : Q30_ONE - term;
      term = ((t2 * acc) >> 30) / 64'd72;
      acc = (term >= Q30_ONE) ? 64'd0 : Q30_ONE - term;
      term = ((t2 * acc) >> 30) / 64'd42;
      acc = (term >= Q30_ONE) ? 64'd0 : Q30_ONE - term;
      term = ((t2 * acc) >> 30) / 64'd20;
      acc = (term >= Q30_ONE) ? 64'd0 : Q30_ONE - term;
      term = ((t2 * acc) >> 30) / 64'd6;
      acc = (term >= Q30_ONE) ? 64'd0 : Q30_ONE - term;
      quarter_sin = 15'((((t * acc) >> 30) + 64'd32768) >> 16);
   endfunction

   function automatic sin_tab_type build_sin_tab();
      sin_tab_type tab;
      for (int i = 0; i <= QTR; i++) begin
         tab[i] = quarter_sin(64'(i) << QSH);
      end
      return tab;
   endfunction

   localparam sin_tab_type SIN_TAB = build_sin_tab();

   // sine of a quantized binary angle, Q1.14
   function automatic logic signed [15:0] bin_sin(input logic [15:0] a);
      logic [14:0] r;
      logic [14:0] mag;
      r = a[15:14] == 2'd1 || a[15:14] == 2'd3 ? 15'd16384 - {1'b0, a[13:0]}
                                               : {1'b0, a[13:0]};
      mag = SIN_TAB[r[QSH +: IDX_W]];
      bin_sin = a[15] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
   endfunction

endpackage

@@ sv/sqvs_front.sv @@
// Front: accepts sprites, forms half sizes, sine/cosine and rotation products.
module sqvs_front import sqvs_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic push,
   output logic full,
   input  sprite_in_type din,
   input  logic signed [15:0] off_x,
   input  logic signed [15:0] off_y,
   output logic q_push,
   output sprite_type q_data,
   input  logic q_full
);

   logic adv;
   logic v1_ff, v2_ff, v3_ff;

   // stage 1
   logic signed [16:0] cx1_ff, cy1_ff;
   logic [15:0] z1_ff, u01_ff, u11_ff, v01_ff, v11_ff, ang1_ff, ax1_ff, ay1_ff;
   logic [31:0] col1_ff, wsx1_ff, wsy1_ff;
   logic [31:0] col_in;
   logic [16:0] usum, vsum;

   // stage 2
   logic signed [16:0] cx2_ff, cy2_ff;
   logic [15:0] z2_ff, u02_ff, u12_ff, v02_ff, v12_ff;
   logic [31:0] col2_ff;
   logic [24:0] hx2_ff, hy2_ff, hx_in, hy_in;
   logic signed [15:0] sn2_ff, cn2_ff;
   logic [47:0] px, py;
   logic [34:0] hxr, hyr;

   sprite_type rec3_ff;

   assign adv = !(v3_ff && q_full);
   assign full = !adv;
   assign q_push = v3_ff && !q_full;
   assign q_data = rec3_ff;

   always_comb begin
      logic [15:0] t;
      logic [16:0] c;
      col_in = '0;
      for (int ch = 0; ch < 4; ch++) begin
         t = 16'(din.sprite_color[8*ch +: 8] * din.anim_color[8*ch +: 8]) + 16'd128;
         c = ({1'b0, t} + {9'd0, t[15:8]}) >> 8;
         col_in[8*ch +: 8] = c[7:0];
      end
   end

   assign usum = {1'b0, din.cell_uv[15:0]} + {1'b0, din.cell_tex_size[15:0]};
   assign vsum = {1'b0, din.cell_uv[31:16]} + {1'b0, din.cell_tex_size[31:16]};

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= push;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cx1_ff <= 17'(off_x) + 17'(din.pos_x);
         cy1_ff <= 17'(off_y) - 17'(din.pos_y);
         z1_ff <= din.pos_z;
         col1_ff <= col_in;
         u01_ff <= din.cell_uv[15:0];
         v01_ff <= din.cell_uv[31:16];
         u11_ff <= usum[16] ? 16'hFFFF : usum[15:0];
         v11_ff <= vsum[16] ? 16'hFFFF : vsum[15:0];
         wsx1_ff <= din.cell_size[15:0] * din.sprite_scale[15:0];
         wsy1_ff <= din.cell_size[31:16] * din.sprite_scale[31:16];
         ax1_ff <= din.anim_scale[15:0];
         ay1_ff <= din.anim_scale[31:16];
         ang1_ff <= (din.sprite_angle + din.anim_angle) & ANG_MASK;
      end
   end

   assign px = wsx1_ff * ax1_ff;
   assign py = wsy1_ff * ay1_ff;
   assign hxr = 35'((px + 48'd4096) >> 13);
   assign hyr = 35'((py + 48'd4096) >> 13);
   assign hx_in = (hxr > 35'd16777216) ? 25'd16777216 : hxr[24:0];
   assign hy_in = (hyr > 35'd16777216) ? 25'd16777216 : hyr[24:0];

   always_ff @(posedge clock) begin
      if (adv) begin
         cx2_ff <= cx1_ff;
         cy2_ff <= cy1_ff;
         z2_ff <= z1_ff;
         col2_ff <= col1_ff;
         u02_ff <= u01_ff;
         u12_ff <= u11_ff;
         v02_ff <= v01_ff;
         v12_ff <= v11_ff;
         hx2_ff <= hx_in;
         hy2_ff <= hy_in;
         sn2_ff <= bin_sin(ang1_ff);
         cn2_ff <= bin_sin(ang1_ff + 16'd16384);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rec3_ff.cx <= cx2_ff;
         rec3_ff.cy <= cy2_ff;
         rec3_ff.z <= z2_ff;
         rec3_ff.color <= col2_ff;
         rec3_ff.u0 <= u02_ff;
         rec3_ff.u1 <= u12_ff;
         rec3_ff.v0 <= v02_ff;
         rec3_ff.v1 <= v12_ff;
         rec3_ff.p_chx <= 42'(cn2_ff) * $signed({1'b0, hx2_ff});
         rec3_ff.p_shy <= 42'(sn2_ff) * $signed({1'b0, hy2_ff});
         rec3_ff.p_shx <= 42'(sn2_ff) * $signed({1'b0, hx2_ff});
         rec3_ff.p_chy <= 42'(cn2_ff) * $signed({1'b0, hy2_ff});
      end
   end

endmodule

@@ sv/sqvs_queue.sv @@
// Short sprite queue between front and back.
module sqvs_queue import sqvs_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic wr,
   input  sprite_type wdata,
   output logic full,
   input  logic rd,
   output sprite_type rdata,
   output logic empty
);

   sprite_type mem_ff [SQ_DEPTH];
   logic [SQ_PTR_W-1:0] wp_ff, rp_ff;
   logic [SQ_PTR_W:0] cnt_ff;

   assign full = cnt_ff == (SQ_PTR_W+1)'(SQ_DEPTH);
   assign empty = cnt_ff == '0;
   assign rdata = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (wr) wp_ff <= (wp_ff == SQ_PTR_W'(SQ_DEPTH - 1)) ? '0 : wp_ff + 1'b1;
         if (rd) rp_ff <= (rp_ff == SQ_PTR_W'(SQ_DEPTH - 1)) ? '0 : rp_ff + 1'b1;
         cnt_ff <= cnt_ff + (SQ_PTR_W+1)'(wr) - (SQ_PTR_W+1)'(rd);
      end
   end

   always_ff @(posedge clock) begin
      if (wr) mem_ff[wp_ff] <= wdata;
   end

endmodule

@@ sv/sqvs_back.sv @@
// Back: walks the four corners of each sprite and buffers the vertices.
module sqvs_back import sqvs_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic q_empty,
   input  sprite_type q_data,
   output logic q_pop,
   output logic empty,
   input  logic pop,
   output vertex_type vout
);

   sprite_type cur_ff;
   logic cur_valid_ff;
   logic [1:0] k_ff;
   logic ob_full, ob_push, ob_pop, done;
   vertex_type vert;
   vertex_type ob_ff [OB_DEPTH];
   logic [OB_PTR_W-1:0] wp_ff, rp_ff;
   logic [OB_PTR_W:0] cnt_ff;

   logic signed [42:0] rx, ry;
   logic signed [24:0] rxq, ryq;
   logic signed [25:0] vx, vy;
   logic neg_x, pos_y;

   assign ob_full = cnt_ff == (OB_PTR_W+1)'(OB_DEPTH);
   assign empty = cnt_ff == '0;
   assign ob_pop = pop && !empty;
   assign ob_push = cur_valid_ff && !ob_full;
   assign done = ob_push && k_ff == CORNER_BL;
   assign q_pop = !q_empty && (!cur_valid_ff || done);
   assign vout = ob_ff[rp_ff];

   // corner signs: x negative on the left, y positive on top
   assign neg_x = k_ff == CORNER_TL || k_ff == CORNER_BL;
   assign pos_y = k_ff == CORNER_TL || k_ff == CORNER_TR;

   always_comb begin
      rx = (neg_x ? -43'(cur_ff.p_chx) : 43'(cur_ff.p_chx))
         + (pos_y ? 43'(cur_ff.p_shy) : -43'(cur_ff.p_shy));
      ry = (neg_x ? 43'(cur_ff.p_shx) : -43'(cur_ff.p_shx))
         + (pos_y ? 43'(cur_ff.p_chy) : -43'(cur_ff.p_chy));
      rxq = 25'((rx + 43'sd131072) >>> 18);
      ryq = 25'((ry + 43'sd131072) >>> 18);
      vx = 26'(rxq) + 26'(cur_ff.cx);
      vy = 26'(ryq) + 26'(cur_ff.cy);
      vert.corner = k_ff;
      vert.x = (vx > 26'sd32767) ? 16'sh7FFF : (vx < -26'sd32768) ? 16'sh8000 : vx[15:0];
      vert.y = (vy > 26'sd32767) ? 16'sh7FFF : (vy < -26'sd32768) ? 16'sh8000 : vy[15:0];
      vert.z = cur_ff.z;
      vert.color = cur_ff.color;
      vert.u = (k_ff == CORNER_TR || k_ff == CORNER_BR) ? cur_ff.u1 : cur_ff.u0;
      vert.v = (k_ff == CORNER_BR || k_ff == CORNER_BL) ? cur_ff.v1 : cur_ff.v0;
      vert.last = k_ff == CORNER_BL;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         k_ff <= CORNER_TL;
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (q_pop) begin
            cur_valid_ff <= 1'b1;
            k_ff <= CORNER_TL;
         end else if (done) begin
            cur_valid_ff <= 1'b0;
            k_ff <= CORNER_TL;
         end else if (ob_push) begin
            k_ff <= k_ff + 2'd1;
         end
         if (ob_push) wp_ff <= (wp_ff == OB_PTR_W'(OB_DEPTH - 1)) ? '0 : wp_ff + 1'b1;
         if (ob_pop) rp_ff <= (rp_ff == OB_PTR_W'(OB_DEPTH - 1)) ? '0 : rp_ff + 1'b1;
         cnt_ff <= cnt_ff + (OB_PTR_W+1)'(ob_push) - (OB_PTR_W+1)'(ob_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) cur_ff <= q_data;
      if (ob_push) ob_ff[wp_ff] <= vert;
   end

endmodule

@@ sv/sprite_quad_vertex_setup.sv @@
// Top level: sprite quad vertex setup with APB register port.
//
// Usage:
//  - Sprites enter on the req_ channel: an item is taken when push is high and
//    full is low. Each sprite yields four vertex items on the rsp_ channel in
//    the order top-left, top-right, bottom-right, bottom-left; rsp_last marks
//    the fourth.
//  - Vertices are queue-style: the oldest one sits on rsp_ while empty is low
//    and leaves on a cycle with pop high.
//  - Front: three pipeline stages (tint/texture/first scale product, second
//    scale product with sine/cosine lookup, four rotation products), then a
//    two-entry sprite queue. Back: while the vertex buffer has room, one vertex
//    per cycle into a two-entry vertex buffer.
//  - A sprite's first vertex passes the three front stages, the sprite queue
//    and the back's current-sprite register on its way to the vertex buffer.
//  - A new sprite can be taken every cycle until the sprite queue fills.
//  - When pop stays low the vertex buffer fills, the back halts, the sprite
//    queue fills and then full rises; nothing is dropped.
//  - Reset (synchronous) empties all queues and clears both screen offsets.
//  - Registers: offset x at 0x0, offset y at 0x4, written during the APB
//    access phase; pready is tied high.
module sprite_quad_vertex_setup import sqvs_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic push,
   output logic full,
   input  logic signed [15:0] req_pos_x,
   input  logic signed [15:0] req_pos_y,
   input  logic [15:0] req_pos_z,
   input  logic [31:0] req_sprite_scale,
   input  logic [31:0] req_anim_scale,
   input  logic [15:0] req_sprite_angle,
   input  logic [15:0] req_anim_angle,
   input  logic [31:0] req_sprite_color,
   input  logic [31:0] req_anim_color,
   input  logic [31:0] req_cell_size,
   input  logic [31:0] req_cell_uv,
   input  logic [31:0] req_cell_tex_size,
   output logic empty,
   input  logic pop,
   output logic [1:0] rsp_corner,
   output logic signed [15:0] rsp_vert_x,
   output logic signed [15:0] rsp_vert_y,
   output logic [15:0] rsp_vert_z,
   output logic [31:0] rsp_vert_color,
   output logic [15:0] rsp_tex_u,
   output logic [15:0] rsp_tex_v,
   output logic rsp_last,
   input  logic psel,
   input  logic penable,
   input  logic pwrite,
   input  logic [2:0] paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic pready
);

   logic signed [15:0] off_x_ff, off_y_ff;
   sprite_in_type din;
   sprite_type q_wdata, q_rdata;
   logic q_push, q_full, q_pop, q_empty;
   vertex_type vout;
   logic csr_wr;

   // register port
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;
   assign prdata = (paddr[2] == REG_OFFSET_Y) ? 32'(off_y_ff) : 32'(off_x_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         off_x_ff <= '0;
         off_y_ff <= '0;
      end else if (csr_wr) begin
         if (paddr[2] == REG_OFFSET_X) off_x_ff <= pwdata[15:0];
         else off_y_ff <= pwdata[15:0];
      end
   end

   always_comb begin
      din.pos_x = req_pos_x;
      din.pos_y = req_pos_y;
      din.pos_z = req_pos_z;
      din.sprite_scale = req_sprite_scale;
      din.anim_scale = req_anim_scale;
      din.sprite_angle = req_sprite_angle;
      din.anim_angle = req_anim_angle;
      din.sprite_color = req_sprite_color;
      din.anim_color = req_anim_color;
      din.cell_size = req_cell_size;
      din.cell_uv = req_cell_uv;
      din.cell_tex_size = req_cell_tex_size;
   end

   sqvs_front u_front (
      .clock(clock), .reset(reset), .push(push), .full(full), .din(din),
      .off_x(off_x_ff), .off_y(off_y_ff),
      .q_push(q_push), .q_data(q_wdata), .q_full(q_full)
   );

   sqvs_queue u_queue (
      .clock(clock), .reset(reset), .wr(q_push), .wdata(q_wdata), .full(q_full),
      .rd(q_pop), .rdata(q_rdata), .empty(q_empty)
   );

   sqvs_back u_back (
      .clock(clock), .reset(reset), .q_empty(q_empty), .q_data(q_rdata),
      .q_pop(q_pop), .empty(empty), .pop(pop), .vout(vout)
   );

   assign rsp_corner = vout.corner;
   assign rsp_vert_x = vout.x;
   assign rsp_vert_y = vout.y;
   assign rsp_vert_z = vout.z;
   assign rsp_vert_color = vout.color;
   assign rsp_tex_u = vout.u;
   assign rsp_tex_v = vout.v;
   assign rsp_last = vout.last;

   // nothing is visible right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> empty)
      else $error("vertex buffer not empty after reset");

   // last flag tracks the final corner
   a_last_corner: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_last == (rsp_corner == CORNER_BL)))
      else $error("last flag out of step with corner");

   // corners leave in strict rotation
   a_corner_order: assert property (@(posedge clock) disable iff (reset)
      (pop && !empty) |=> (empty || rsp_corner == $past(rsp_corner) + 2'd1))
      else $error("corner order broken");

   // queue never written while full
   a_queue_guard: assert property (@(posedge clock) disable iff (reset)
      !(q_push && q_full))
      else $error("sprite queue overrun");

endmodule

@@ tb/tb_top.sv @@
// Testbench for the sprite quad vertex setup: directed, offset, random and backpressure tests.
module tb_top import sqvs_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 12;      // margin over the pipeline latency plus buffers
   localparam logic [2:0] ADDR_OFF_X = 3'(REG_OFFSET_X) << 2;
   localparam logic [2:0] ADDR_OFF_Y = 3'(REG_OFFSET_Y) << 2;

   logic clock = 0;
   logic reset = 1;
   logic push = 0;
   logic pop = 0;
   logic full, empty;
   sprite_in_type req = '0;
   wire vertex_type rsp;
   logic psel = 0, penable = 0, pwrite = 0;
   logic [2:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   // predictor copy of the offset registers
   logic signed [15:0] off_x = '0;
   logic signed [15:0] off_y = '0;

   vertex_type vertex_q[$];   // vertices still owed by the block
   int errors = 0;
   int idle_cycles = 0;
   int hold_req = 0;          // long receiver hold requested by a test

   sprite_quad_vertex_setup i_dut (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .req_pos_x(req.pos_x), .req_pos_y(req.pos_y), .req_pos_z(req.pos_z),
      .req_sprite_scale(req.sprite_scale), .req_anim_scale(req.anim_scale),
      .req_sprite_angle(req.sprite_angle), .req_anim_angle(req.anim_angle),
      .req_sprite_color(req.sprite_color), .req_anim_color(req.anim_color),
      .req_cell_size(req.cell_size), .req_cell_uv(req.cell_uv),
      .req_cell_tex_size(req.cell_tex_size),
      .empty(empty), .pop(pop),
      .rsp_corner(rsp.corner), .rsp_vert_x(rsp.x), .rsp_vert_y(rsp.y),
      .rsp_vert_z(rsp.z), .rsp_vert_color(rsp.color), .rsp_tex_u(rsp.u),
      .rsp_tex_v(rsp.v), .rsp_last(rsp.last),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Sine of r in 0..16384 (quarter turn), Q1.14. Taylor series in Q30,
   // folded Horner style from the t^11 term down.
   function automatic int quarter_wave_sine(int unsigned r);
      longint unsigned t, t2, acc, term;
      t = (64'(r) * 64'd3373259426) >> 15;
      t2 = (t * t) >> 30;
      acc = 64'd1 << 30;
      for (int n = 10; n >= 2; n -= 2) begin
         term = ((t2 * acc) >> 30) / 64'(n * (n + 1));
         acc = (term >= (64'd1 << 30)) ? 64'd0 : (64'd1 << 30) - term;
      end
      return int'((((t * acc) >> 30) + 64'd32768) >> 16);
   endfunction

   function automatic int angle_sine(logic [15:0] a);
      int s;
      s = a[14] ? quarter_wave_sine(16384 - a[13:0]) : quarter_wave_sine(a[13:0]);
      return a[15] ? -s : s;
   endfunction

   function automatic longint half_extent(logic [15:0] w, logic [15:0] s, logic [15:0] a);
      longint unsigned h;
      h = (64'(w) * 64'(s) * 64'(a) + 64'd4096) >> 13;
      return (h > (64'd1 << 24)) ? (64'd1 << 24) : h;
   endfunction

   // Q.22 to Q.4, round half up (floor of v + 2^17 shifted by 18)
   function automatic longint q22_to_q4(longint v);
      return (v + 64'sd131072) >>> 18;
   endfunction

   function automatic logic [15:0] clamp_s16(longint v);
      if (v > 32767) return 16'h7FFF;
      if (v < -32768) return 16'h8000;
      return 16'(v);
   endfunction

   // Works out the four corner vertices of one sprite and queues them.
   task automatic predict_vertices(sprite_in_type s);
      longint cx, cy, hx, hy, x, y, sn, cn, rx, ry;
      logic [15:0] ang;
      logic [16:0] u1, v1;
      logic [31:0] tint;
      vertex_type vx;
      cx = longint'(off_x) + longint'(s.pos_x);
      cy = longint'(off_y) - longint'(s.pos_y);
      hx = half_extent(s.cell_size[15:0], s.sprite_scale[15:0], s.anim_scale[15:0]);
      hy = half_extent(s.cell_size[31:16], s.sprite_scale[31:16], s.anim_scale[31:16]);
      ang = s.sprite_angle + s.anim_angle;
      ang = ang & ~16'((32'd1 << (16 - SINE_TABLE_LOG2)) - 1);
      sn = angle_sine(ang);
      cn = angle_sine(ang + 16'd16384);
      for (int ch = 0; ch < 4; ch++) begin
         tint[8*ch +: 8] = 8'((32'(s.sprite_color[8*ch +: 8]) *
                               32'(s.anim_color[8*ch +: 8]) + 127) / 255);
      end
      u1 = 17'(s.cell_uv[15:0]) + 17'(s.cell_tex_size[15:0]);
      v1 = 17'(s.cell_uv[31:16]) + 17'(s.cell_tex_size[31:16]);
      if (u1[16]) u1 = 17'hFFFF;
      if (v1[16]) v1 = 17'hFFFF;
      for (int k = 0; k < 4; k++) begin
         x = (k == 0 || k == 3) ? -hx : hx;
         y = (k < 2) ? hy : -hy;
         rx = q22_to_q4(cn * x + sn * y);
         ry = q22_to_q4(-sn * x + cn * y);
         vx.corner = 2'(k);
         vx.x = clamp_s16(cx + rx);
         vx.y = clamp_s16(cy + ry);
         vx.z = s.pos_z;
         vx.color = tint;
         vx.u = (k == 1 || k == 2) ? u1[15:0] : s.cell_uv[15:0];
         vx.v = (k >= 2) ? v1[15:0] : s.cell_uv[31:16];
         vx.last = (k == 3);
         vertex_q.push_back(vx);
      end
   endtask

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("MISMATCH %s: got %h expected %h (corner %0d)", what, got, want, rsp.corner);
   endtask

   // Pre-edge sampling: accepted sprites feed the predictor, popped vertices
   // are checked against the oldest owed one.
   always @(posedge clock) begin
      vertex_type w;
      if (!reset) begin
         if ((push && !full) || (pop && !empty)) idle_cycles = 0;
         else idle_cycles++;
         if (push && !full) predict_vertices(req);
         if (pop && !empty) begin
            if (vertex_q.size() == 0) begin
               report_mismatch("unexpected vertex", 32'(rsp.corner), 32'd0);
            end else begin
               w = vertex_q.pop_front();
               if (rsp.corner !== w.corner) report_mismatch("corner", rsp.corner, w.corner);
               if (rsp.x !== w.x) report_mismatch("vert_x", rsp.x, w.x);
               if (rsp.y !== w.y) report_mismatch("vert_y", rsp.y, w.y);
               if (rsp.z !== w.z) report_mismatch("vert_z", rsp.z, w.z);
               if (rsp.color !== w.color) report_mismatch("vert_color", rsp.color, w.color);
               if (rsp.u !== w.u) report_mismatch("tex_u", rsp.u, w.u);
               if (rsp.v !== w.v) report_mismatch("tex_v", rsp.v, w.v);
               if (rsp.last !== w.last) report_mismatch("last", rsp.last, w.last);
            end
         end
      end
   end

   // watchdog: too long with nothing moving on either side
   always @(posedge clock) begin
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout after %0d idle cycles, %0d vertices owed",
                  idle_cycles, vertex_q.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Receiver: pop pattern changes every random stretch; a requested hold
   // keeps pop low while hold_req counts down to zero.
   initial begin
      int mode, left;
      mode = 0;
      left = 0;
      forever begin
         @(negedge clock);
         if (hold_req > 0) begin
            pop = 1'b0;
            hold_req--;
         end else begin
            if (left == 0) begin
               mode = $urandom_range(3);
               left = $urandom_range(60, 5);
            end
            left--;
            case (mode)
               0: pop = 1'b1;
               1: pop = 1'($urandom_range(1));
               2: pop = ($urandom_range(3) == 0);
               default: pop = ($urandom_range(9) != 0);
            endcase
         end
      end
   end

   // one sprite: present it, wait for it to be taken, leave push high
   task automatic send_sprite(sprite_in_type s);
      req = s;
      push = 1;
      do @(posedge clock); while (full);
      @(negedge clock);
   endtask

   task automatic gap_between_bursts();
      push = 0;
      repeat ($urandom_range(6, 1)) @(negedge clock);
   endtask

   task automatic wait_idle();
      push = 0;
      while (vertex_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_offset(logic [2:0] addr, logic signed [15:0] value);
      psel = 1;
      penable = 0;
      pwrite = 1;
      paddr = addr;
      pwdata = 32'(value);
      @(negedge clock);
      penable = 1;
      @(negedge clock);
      psel = 0;
      penable = 0;
      pwrite = 0;
      if (addr == ADDR_OFF_X) off_x = value;
      else if (addr == ADDR_OFF_Y) off_y = value;
   endtask

   function automatic sprite_in_type unit_sprite();
      sprite_in_type s;
      s = '0;
      s.sprite_scale = 32'h0100_0100;
      s.anim_scale = 32'h0100_0100;
      s.cell_size = 32'h0200_0200;
      s.sprite_color = 32'hFFFF_FFFF;
      s.anim_color = 32'hFFFF_FFFF;
      return s;
   endfunction

   function automatic sprite_in_type random_sprite();
      sprite_in_type s;
      s = unit_sprite();
      s.pos_x = 16'($urandom);
      s.pos_y = 16'($urandom);
      s.pos_z = 16'($urandom);
      s.sprite_angle = 16'($urandom);
      s.anim_angle = 16'($urandom);
      s.sprite_color = $urandom;
      s.anim_color = $urandom;
      s.cell_uv = $urandom;
      s.cell_tex_size = $urandom_range(3) == 0 ? $urandom : $urandom & 32'h0FFF_0FFF;
      case ($urandom_range(9))
         0: begin   // anything at all, mostly saturating
            s.sprite_scale = $urandom;
            s.anim_scale = $urandom;
            s.cell_size = $urandom;
         end
         1, 2: begin
            s.sprite_scale = $urandom & 32'h03FF_03FF;
            s.anim_scale = $urandom & 32'h03FF_03FF;
            s.cell_size = $urandom & 32'h3FFF_3FFF;
         end
         default: begin   // plausible sprites, a few pixels to a few hundred
            s.sprite_scale = {16'($urandom_range(512, 64)), 16'($urandom_range(512, 64))};
            s.anim_scale = {16'($urandom_range(384, 128)), 16'($urandom_range(384, 128))};
            s.cell_size = {16'($urandom_range(4096)), 16'($urandom_range(4096))};
         end
      endcase
      return s;
   endfunction

   task automatic test_directed();
      sprite_in_type s;
      send_sprite(unit_sprite());
      s = '0;                                   // all zero: degenerate quad, black
      send_sprite(s);
      s = '1;                                   // all ones: every field at its top
      send_sprite(s);
      for (int q = 0; q < 4; q++) begin         // each quadrant boundary
         s = unit_sprite();
         s.sprite_angle = 16'(q * 16384);
         send_sprite(s);
      end
      s = unit_sprite();                        // summed angle wraps past a full turn
      s.sprite_angle = 16'hC123;
      s.anim_angle = 16'h7F45;
      send_sprite(s);
      s = unit_sprite();                        // low angle bits below table step
      s.sprite_angle = 16'h003F;
      send_sprite(s);
      s = unit_sprite();                        // positions pinned at the rails
      s.pos_x = 16'sh7FFF;
      s.pos_y = -16'sh8000;
      send_sprite(s);
      s.pos_x = -16'sh8000;
      s.pos_y = 16'sh7FFF;
      send_sprite(s);
      s = unit_sprite();                        // huge half size saturates
      s.cell_size = 32'hFFFF_FFFF;
      s.sprite_scale = 32'hFFFF_FFFF;
      s.anim_scale = 32'hFFFF_FFFF;
      s.sprite_angle = 16'h2000;
      send_sprite(s);
      s = unit_sprite();                        // texture coordinates overflow
      s.cell_uv = 32'hFF00_FFF0;
      s.cell_tex_size = 32'h0100_0010;
      send_sprite(s);
      s.cell_uv = 32'hFFFF_FFFF;
      s.cell_tex_size = 32'h0000_0001;
      send_sprite(s);
      s = unit_sprite();                        // tint rounding per channel
      s.sprite_color = 32'h80FF_0001;
      s.anim_color = 32'h8001_FF7F;
      send_sprite(s);
      wait_idle();
   endtask

   task automatic test_offsets();
      logic signed [15:0] xs[4];
      logic signed [15:0] ys[4];
      xs = '{-16'sh8000, 16'sh7FFF, 16'sh0000, 16'sh1234};
      ys = '{16'sh7FFF, -16'sh8000, 16'sh0000, -16'sh0567};
      for (int p = 0; p < 4; p++) begin
         write_offset(ADDR_OFF_X, xs[p]);
         write_offset(ADDR_OFF_Y, ys[p]);
         for (int n = 0; n < 6; n++) send_sprite(random_sprite());
         wait_idle();
      end
   endtask

   task automatic test_random();
      int sent, burst;
      sent = 0;
      while (sent < 170) begin
         burst = $urandom_range(12, 1);
         for (int n = 0; n < burst; n++) send_sprite(random_sprite());
         sent += burst;
         if ($urandom_range(4) != 0) gap_between_bursts();
         if (sent >= 85 && sent - burst < 85) begin
            wait_idle();
            write_offset(ADDR_OFF_X, 16'($urandom));
            write_offset(ADDR_OFF_Y, 16'($urandom));
         end
      end
      wait_idle();
   endtask

   // receiver holds off while sprites keep coming, so full must rise
   task automatic test_backpressure();
      hold_req = 300;
      for (int n = 0; n < 20; n++) send_sprite(random_sprite());
      wait_idle();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 0;
      test_directed();
      test_offsets();
      test_backpressure();
      test_random();
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
